>>> hw/rtl/zlss_pkg.sv
// Shared types and constants for the zip local entry stream scanner.
package zlss_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_EXTRA  = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // final status codes
  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_NEED_MORE  = 2'd2;
  localparam logic [1:0] ST_UNREADABLE = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NOT_ZIP  = 3'd1;
  localparam logic [2:0] ERR_STRAY    = 3'd2;
  localparam logic [2:0] ERR_STREAMED = 3'd3;
  localparam logic [2:0] ERR_ENCRYPT  = 3'd4;
  localparam logic [2:0] ERR_ZIP64    = 3'd5;
  localparam logic [2:0] ERR_METHOD   = 3'd6;

  localparam logic [31:0] SIG_LOCAL_HDR = 32'h04034b50;
  localparam logic [31:0] SIG_CENTRAL   = 32'h02014b50;
  localparam logic [31:0] SIG_END_DIR   = 32'h06054b50;
  localparam logic [31:0] SIZE_ALL_ONES = 32'hFFFFFFFF;
  localparam logic [31:0] HDR_BYTES     = 32'd30;

  localparam int FLAG_STREAMED_BIT  = 3;
  localparam int FLAG_ENCRYPTED_BIT = 0;

  localparam logic [15:0] METHOD_STORED  = 16'd0;
  localparam logic [15:0] METHOD_DEFLATE = 16'd8;

  localparam logic [31:0] TAIL_VCV  = 32'h2E766376;  // ".vcv"
  localparam logic [39:0] TAIL_VCVS = 40'h2E76637673; // ".vcvs"

  // Results caused by one archive byte: an optional name/payload byte,
  // then an optional final status.
  typedef struct packed {
    logic        byte_vld;
    logic [1:0]  byte_kind;
    logic [7:0]  byte_value;
    logic        name_start;
    logic        stat_vld;
    logic [1:0]  status;
    logic [2:0]  error_code;
    logic [15:0] method;
    logic [31:0] usize;
  } bundle_t;

endpackage

>>> hw/rtl/zlss_front.sv
// Front end: header walker that turns each archive byte into a result bundle.
module zlss_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [7:0]       data_byte,
  input  logic             q_full,
  output logic             push,
  output zlss_pkg::bundle_t push_data
);
  import zlss_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] cnt, cnt_next, cnt_inc;
  logic        first_entry, first_next;
  logic [31:0] signature, sig_next;
  logic [15:0] flags, flags_next;
  logic [15:0] meth, meth_next;
  logic [31:0] csize, csize_next;
  logic [31:0] usize, usize_next;
  logic [15:0] nlen, nlen_next;
  logic [15:0] xlen, xlen_next, xlen_use;
  logic [39:0] tail, tail_next, tail_use;
  logic        wanted, wanted_next, wanted_use;
  logic        finished, fin_next;
  logic        an_go, ex_go, dt_go, end_go;
  logic        meth_ok;
  logic [7:0]  lc;
  logic        accept;
  bundle_t     bnd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cnt_inc  = cnt + 32'd1;
  assign meth_ok  = (meth == METHOD_STORED) || (meth == METHOD_DEFLATE);

  always_comb begin
    lc = data_byte;
    if (data_byte inside {[8'h41:8'h5A]}) lc = data_byte + 8'h20;
  end

  always_comb begin
    phase_next  = phase;
    cnt_next    = cnt;
    first_next  = first_entry;
    sig_next    = signature;
    flags_next  = flags;
    meth_next   = meth;
    csize_next  = csize;
    usize_next  = usize;
    nlen_next   = nlen;
    xlen_next   = xlen;
    tail_next   = tail;
    wanted_next = wanted;
    fin_next    = finished;
    bnd         = '0;
    an_go       = 1'b0;
    ex_go       = 1'b0;
    dt_go       = 1'b0;
    end_go      = 1'b0;
    xlen_use    = xlen;
    tail_use    = tail;
    wanted_use  = wanted;
    if (mode) begin
      if (!finished) begin
        bnd.stat_vld = 1'b1;
        bnd.status   = ST_NEED_MORE;
      end
      phase_next  = PH_HEADER;
      cnt_next    = '0;
      first_next  = 1'b1;
      sig_next    = '0;
      flags_next  = '0;
      meth_next   = '0;
      csize_next  = '0;
      usize_next  = '0;
      nlen_next   = '0;
      xlen_next   = '0;
      tail_next   = '0;
      wanted_next = 1'b0;
      fin_next    = 1'b0;
    end else if (!finished) begin
      case (phase)
        PH_HEADER: begin
          // little-endian fields shift in from the top
          if (cnt < 32'd4) sig_next = {data_byte, signature[31:8]};
          else if (cnt == 32'd6 || cnt == 32'd7) flags_next = {data_byte, flags[15:8]};
          else if (cnt == 32'd8 || cnt == 32'd9) meth_next = {data_byte, meth[15:8]};
          else if (cnt >= 32'd18 && cnt < 32'd22) csize_next = {data_byte, csize[31:8]};
          else if (cnt >= 32'd22 && cnt < 32'd26) usize_next = {data_byte, usize[31:8]};
          else if (cnt == 32'd26 || cnt == 32'd27) nlen_next = {data_byte, nlen[15:8]};
          else if (cnt == 32'd28 || cnt == 32'd29) xlen_next = {data_byte, xlen[15:8]};
          cnt_next = cnt_inc;
          xlen_use = xlen_next;
          if (cnt_inc == HDR_BYTES) begin
            if (signature != SIG_LOCAL_HDR) begin
              bnd.stat_vld = 1'b1;
              fin_next     = 1'b1;
              if (signature == SIG_CENTRAL || signature == SIG_END_DIR) begin
                bnd.status = ST_NOT_FOUND;
              end else begin
                bnd.status     = ST_UNREADABLE;
                bnd.error_code = first_entry ? ERR_NOT_ZIP : ERR_STRAY;
              end
            end else begin
              phase_next  = PH_NAME;
              cnt_next    = '0;
              tail_next   = '0;
              tail_use    = '0;
              wanted_next = 1'b0;
              if (nlen_next == 16'd0) an_go = 1'b1;
            end
          end
        end
        PH_NAME: begin
          bnd.byte_vld   = 1'b1;
          bnd.byte_kind  = KIND_NAME;
          bnd.byte_value = data_byte;
          bnd.name_start = (cnt == 32'd0);
          tail_use       = {tail[31:0], lc};
          tail_next      = tail_use;
          cnt_next       = cnt_inc;
          if (cnt_inc == {16'd0, nlen}) an_go = 1'b1;
        end
        PH_EXTRA: begin
          cnt_next = cnt_inc;
          if (cnt_inc == {16'd0, xlen}) dt_go = 1'b1;
        end
        PH_DATA: begin
          if (wanted && meth_ok) begin
            bnd.byte_vld   = 1'b1;
            bnd.byte_kind  = KIND_PAYLOAD;
            bnd.byte_value = data_byte;
          end
          cnt_next = cnt_inc;
          if (cnt_inc == csize) end_go = 1'b1;
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase

      // end of name: flag checks, then suffix match
      if (an_go) begin
        if (flags[FLAG_STREAMED_BIT]) begin
          bnd.stat_vld   = 1'b1;
          bnd.status     = ST_UNREADABLE;
          bnd.error_code = ERR_STREAMED;
          fin_next       = 1'b1;
        end else if (flags[FLAG_ENCRYPTED_BIT]) begin
          bnd.stat_vld   = 1'b1;
          bnd.status     = ST_UNREADABLE;
          bnd.error_code = ERR_ENCRYPT;
          fin_next       = 1'b1;
        end else if (csize == SIZE_ALL_ONES || usize == SIZE_ALL_ONES) begin
          bnd.stat_vld   = 1'b1;
          bnd.status     = ST_UNREADABLE;
          bnd.error_code = ERR_ZIP64;
          fin_next       = 1'b1;
        end else begin
          wanted_use  = (tail_use[31:0] == TAIL_VCV) || (tail_use == TAIL_VCVS);
          wanted_next = wanted_use;
          ex_go       = 1'b1;
        end
      end
      if (ex_go) begin
        phase_next = PH_EXTRA;
        cnt_next   = '0;
        if (xlen_use == 16'd0) dt_go = 1'b1;
      end
      if (dt_go) begin
        phase_next = PH_DATA;
        cnt_next   = '0;
        if (csize == 32'd0) end_go = 1'b1;
      end
      if (end_go) begin
        if (wanted_use) begin
          bnd.stat_vld = 1'b1;
          fin_next     = 1'b1;
          if (meth_ok) begin
            bnd.status = ST_FOUND;
            bnd.method = meth;
            bnd.usize  = usize;
          end else begin
            bnd.status     = ST_UNREADABLE;
            bnd.error_code = ERR_METHOD;
          end
        end else begin
          phase_next = PH_HEADER;
          cnt_next   = '0;
          first_next = 1'b0;
        end
      end
    end
  end

  assign push      = accept && (bnd.byte_vld || bnd.stat_vld);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      cnt         <= '0;
      first_entry <= 1'b1;
      signature   <= '0;
      flags       <= '0;
      meth        <= '0;
      csize       <= '0;
      usize       <= '0;
      nlen        <= '0;
      xlen        <= '0;
      tail        <= '0;
      wanted      <= 1'b0;
      finished    <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      cnt         <= cnt_next;
      first_entry <= first_next;
      signature   <= sig_next;
      flags       <= flags_next;
      meth        <= meth_next;
      csize       <= csize_next;
      usize       <= usize_next;
      nlen        <= nlen_next;
      xlen        <= xlen_next;
      tail        <= tail_next;
      wanted      <= wanted_next;
      finished    <= fin_next;
    end
  end

  // after a final status only end of data may produce anything
  a_quiet_when_done: assert property (@(posedge clk) disable iff (rst)
    (accept && finished && !mode) |-> !push)
    else $error("result produced after final status");

  a_status_latches: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.stat_vld && push_data.status != ST_NEED_MORE) |=> finished)
    else $error("final status did not stop the scanner");

  a_start_on_name: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.name_start) |->
      (push_data.byte_vld && push_data.byte_kind == KIND_NAME))
    else $error("name start flag on a non-name result");

endmodule

>>> hw/rtl/zlss_queue.sv
// Small bundle queue between the header walker and the output stage.
module zlss_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  zlss_pkg::bundle_t push_data,
  input  logic              pop,
  output zlss_pkg::bundle_t head,
  output logic              full,
  output logic              not_empty
);
  import zlss_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  bundle_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue underflow");

endmodule

>>> hw/rtl/zlss_back.sv
// Output stage: unpacks each bundle into one or two result transfers.
module zlss_back (
  input  logic              clk,
  input  logic              rst,
  input  zlss_pkg::bundle_t head,
  input  logic              not_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [7:0]        byte_value,
  output logic              name_start,
  output logic [1:0]        status,
  output logic [2:0]        error_code,
  output logic [15:0]       method,
  output logic [31:0]       uncompressed_size,
  output logic              last
);
  import zlss_pkg::*;

  bundle_t slot;
  logic    sel;       // 1 once the byte part has been transferred
  logic    show_stat;
  logic    fire, done;

  assign show_stat = sel || !slot.byte_vld;
  assign fire      = out_valid && out_ready;
  assign done      = show_stat || !slot.stat_vld;
  assign pop       = not_empty && (!out_valid || (fire && done));

  always_ff @(posedge clk) begin
    if (pop) slot <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
      sel       <= 1'b0;
    end else if (fire) begin
      out_valid <= !done;
      sel       <= !done;
    end
  end

  always_comb begin
    if (show_stat) begin
      kind              = KIND_STATUS;
      byte_value        = '0;
      name_start        = 1'b0;
      status            = slot.status;
      error_code        = slot.error_code;
      method            = slot.method;
      uncompressed_size = slot.usize;
    end else begin
      kind              = slot.byte_kind;
      byte_value        = slot.byte_value;
      name_start        = slot.name_start;
      status            = ST_FOUND;
      error_code        = ERR_NONE;
      method            = '0;
      uncompressed_size = '0;
    end
  end

  assign last = done;

  a_stat_part_exists: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sel) |-> (slot.byte_vld && slot.stat_vld))
    else $error("status part shown for a bundle without one");

  a_split_follows: assert property (@(posedge clk) disable iff (rst)
    (fire && !done) |=> (out_valid && sel))
    else $error("status part of a split bundle was lost");

endmodule

>>> hw/rtl/zip_local_entry_stream_scanner_core.sv
// Top level of the zip local entry stream scanner.
// Feed the archive one byte per transfer on the input channel (mode 0) and
// send mode 1 when no more bytes are available now; that transfer reports
// need more (unless a final status already went out) and returns the block
// to its reset state. The scanner walks the local file headers, passes every
// entry name byte out as a kind 0 result (name_start marks the first of an
// entry), skips extra fields and the data of other entries, and for the first
// entry whose name ends in ".vcv" or ".vcvs" (any case) passes its data out
// raw as kind 1 results followed by a found status carrying the method and
// uncompressed size. Deflate data is not inflated. A central directory or
// end-of-directory signature gives not found; streamed sizes, encryption,
// zip64 sizes, an unknown method on the wanted entry or a bad signature give
// unreadable with an error code. After a final status further bytes are
// taken and dropped until mode 1. The header walker takes one byte per clock
// and never stalls on its own; it only waits when the queue of QUEUE_DEPTH
// result bundles in front of the output stage is full. The output stage
// moves one result per clock, so a byte that causes two results (a last name
// byte together with a status) takes two output transfers; sustained rate
// is one byte per clock while the sink keeps out_ready high. There is no
// clearing pass after reset; the first byte is taken on the cycle after rst
// drops. last marks the final result that an input transfer produces.
module zip_local_entry_stream_scanner_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  byte_value,
  output logic        name_start,
  output logic [1:0]  status,
  output logic [2:0]  error_code,
  output logic [15:0] method,
  output logic [31:0] uncompressed_size,
  output logic        last
);
  import zlss_pkg::*;

  logic    q_full, q_not_empty;
  logic    push, pop;
  bundle_t push_data, head;

  // front: header walker, one archive byte per transfer
  zlss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue of result bundles
  zlss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // back: registered output, splits two-result bundles
  zlss_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .not_empty         (q_not_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .kind              (kind),
    .byte_value        (byte_value),
    .name_start        (name_start),
    .status            (status),
    .error_code        (error_code),
    .method            (method),
    .uncompressed_size (uncompressed_size),
    .last              (last)
  );

  a_found_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_STATUS) |-> (method == 16'd0 && uncompressed_size == 32'd0))
    else $error("header fields leaked onto a byte result");

endmodule
